// File: hdl/hcbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam int SIZE_BITS_DEF = 63;
    localparam int MAX_DIGITS    = 19;
    localparam int DCNT_W        = 5;
    localparam int TOTAL_W       = 64;

    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_HT   = 8'h09;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF_H = 8'h66;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;

    typedef enum logic [2:0] {
        PH_LEAD    = 3'd0,
        PH_DIGITS  = 3'd1,
        PH_TRAIL   = 3'd2,
        PH_DATA    = 3'd3,
        PH_TAIL    = 3'd4,
        PH_TAIL_CR = 3'd5,
        PH_ENDED   = 3'd6,
        PH_FAILED  = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        ST_FRAMING = 2'd0,
        ST_PAYLOAD = 2'd1,
        ST_END     = 2'd2,
        ST_ERROR   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_NON_HEX   = 3'd1,
        ERR_TOO_LONG  = 3'd2,
        ERR_NO_LF     = 3'd3,
        ERR_TOO_LARGE = 3'd4,
        ERR_TAIL_LF   = 3'd5
    } t_err;

    // classified input word
    typedef struct packed {
        logic       restart;
        logic [7:0] data;
        logic       is_hex;
        logic [3:0] hex;
        logic       is_blank;   // SP, HT or CR
        logic       is_cr;
        logic       is_lf;
    } t_cls;

    typedef struct packed {
        logic               data_valid;
        logic [7:0]         data_byte;
        t_status            status;
        t_err               error_kind;
        logic [TOTAL_W-1:0] bytes_consumed;
    } t_result;

endpackage
`default_nettype wire

// File: hdl/hcbd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_queue
// Two-entry first-word-fall-through queue.
// ----------------------------------------------------------------------------
module hcbd_queue #(
    parameter int W = 1
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_din,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_dout,
    output logic              o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         w_push;
    logic         w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_dout  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_din;
        end
    end

endmodule
`default_nettype wire

// File: hdl/hcbd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_front
// Accepts raw bytes and registers them with their character class.
// ----------------------------------------------------------------------------
module hcbd_front
    import hcbd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_restart,
    output logic            o_full,
    output logic            o_valid,
    output t_cls            o_cls,
    input  wire logic       i_take
);

    logic r_valid;
    t_cls r_cls;
    t_cls w_cls;
    logic w_accept;

    always_comb begin
        w_cls          = '0;
        w_cls.restart  = i_restart;
        w_cls.data     = i_in_byte;
        w_cls.is_cr    = (i_in_byte == CH_CR);
        w_cls.is_lf    = (i_in_byte == CH_LF);
        w_cls.is_blank = (i_in_byte == CH_SP) || (i_in_byte == CH_HT) || w_cls.is_cr;
        if (i_in_byte >= CH_ZERO && i_in_byte <= CH_NINE) begin
            w_cls.is_hex = 1'b1;
            w_cls.hex    = 4'(i_in_byte - CH_ZERO);
        end else if (i_in_byte >= CH_LA && i_in_byte <= CH_LF_H) begin
            w_cls.is_hex = 1'b1;
            w_cls.hex    = 4'(i_in_byte - CH_LA + 8'd10);
        end else if (i_in_byte >= CH_UA && i_in_byte <= CH_UF) begin
            w_cls.is_hex = 1'b1;
            w_cls.hex    = 4'(i_in_byte - CH_UA + 8'd10);
        end
    end

    assign o_full   = r_valid && !i_take;
    assign w_accept = i_push && !o_full;
    assign o_valid  = r_valid;
    assign o_cls    = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept || (r_valid && !i_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cls <= w_cls;
        end
    end

endmodule
`default_nettype wire

// File: hdl/hcbd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_back
// Framing state machine: size line parse, payload count, last-chunk line.
// ----------------------------------------------------------------------------
module hcbd_back
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_go,
    input  t_cls      i_cls,
    output t_result   o_res
);

    t_phase                r_phase, n_phase, w_phase;
    logic [SIZE_BITS-1:0]  r_chunk, n_chunk, w_chunk;
    logic [DCNT_W-1:0]     r_dcnt, n_dcnt, w_dcnt;
    logic                  r_lz, n_lz, w_lz;
    logic                  r_ovf, n_ovf, w_ovf;
    logic [TOTAL_W-1:0]    r_total, n_total;
    t_err                  w_err;
    logic                  w_line_end;

    // restart clears everything before the word is taken
    always_comb begin
        if (i_cls.restart) begin
            w_phase = PH_LEAD;
            w_chunk = '0;
            w_dcnt  = '0;
            w_lz    = 1'b0;
            w_ovf   = 1'b0;
        end else begin
            w_phase = r_phase;
            w_chunk = r_chunk;
            w_dcnt  = r_dcnt;
            w_lz    = r_lz;
            w_ovf   = r_ovf;
        end
    end

    // datapath and result
    always_comb begin
        n_chunk    = w_chunk;
        n_dcnt     = w_dcnt;
        n_lz       = w_lz;
        n_ovf      = w_ovf;
        n_total    = i_cls.restart ? '0 : r_total;
        w_err      = ERR_NONE;
        w_line_end = 1'b0;
        o_res      = '0;
        if (w_phase != PH_ENDED && w_phase != PH_FAILED) begin
            n_total = n_total + 1'b1;
        end
        unique case (w_phase)
            PH_LEAD: begin
                if (!(i_cls.is_blank || i_cls.is_lf)) begin
                    if (!i_cls.is_hex) begin
                        w_err = ERR_NON_HEX;
                    end else begin
                        n_chunk = {{(SIZE_BITS-4){1'b0}}, i_cls.hex};
                        n_dcnt  = DCNT_W'(1);
                        n_lz    = (i_cls.hex == 4'd0);
                        n_ovf   = 1'b0;
                    end
                end
            end
            PH_DIGITS: begin
                if (i_cls.is_hex) begin
                    if (!(w_lz && i_cls.hex == 4'd0)) begin
                        n_lz = 1'b0;
                        if (w_dcnt >= DCNT_W'(MAX_DIGITS)) begin
                            w_err = ERR_TOO_LONG;
                        end else begin
                            if (w_chunk[SIZE_BITS-1 -: 4] != 4'd0) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_chunk = {w_chunk[SIZE_BITS-5:0], i_cls.hex};
                            end
                            n_dcnt = w_dcnt + 1'b1;
                        end
                    end
                end else if (!i_cls.is_blank) begin
                    if (!i_cls.is_lf) begin
                        w_err = ERR_NO_LF;
                    end else begin
                        w_line_end = 1'b1;
                    end
                end
            end
            PH_TRAIL: begin
                if (!i_cls.is_blank) begin
                    if (!i_cls.is_lf) begin
                        w_err = ERR_NO_LF;
                    end else begin
                        w_line_end = 1'b1;
                    end
                end
            end
            PH_DATA: begin
                o_res.data_valid = 1'b1;
                o_res.data_byte  = i_cls.data;
                o_res.status     = ST_PAYLOAD;
                if (w_chunk != '0) begin
                    n_chunk = w_chunk - 1'b1;
                end
            end
            PH_TAIL: begin
                if (i_cls.is_lf) begin
                    o_res.status = ST_END;
                end else if (!i_cls.is_cr) begin
                    w_err = ERR_TAIL_LF;
                end
            end
            PH_TAIL_CR: begin
                if (i_cls.is_lf) begin
                    o_res.status = ST_END;
                end else begin
                    w_err = ERR_TAIL_LF;
                end
            end
            PH_ENDED: begin
                o_res.status = ST_END;
            end
            PH_FAILED: begin
                o_res.status = ST_ERROR;
            end
        endcase
        if (w_line_end) begin
            if (w_ovf) begin
                w_err = ERR_TOO_LARGE;
            end else begin
                n_dcnt = '0;
                n_lz   = 1'b0;
            end
        end
        if (w_err != ERR_NONE) begin
            o_res.status = ST_ERROR;
        end
        o_res.error_kind     = w_err;
        o_res.bytes_consumed = n_total;
    end

    // next phase
    always_comb begin
        n_phase = w_phase;
        if (w_err != ERR_NONE) begin
            n_phase = PH_FAILED;
        end else if (w_line_end) begin
            n_phase = (w_chunk != '0) ? PH_DATA : PH_TAIL;
        end else begin
            unique case (w_phase)
                PH_LEAD: begin
                    if (!(i_cls.is_blank || i_cls.is_lf)) begin
                        n_phase = PH_DIGITS;
                    end
                end
                PH_DIGITS: begin
                    if (!i_cls.is_hex && i_cls.is_blank) begin
                        n_phase = PH_TRAIL;
                    end
                end
                PH_DATA: begin
                    if (n_chunk == '0) begin
                        n_phase = PH_LEAD;
                    end
                end
                PH_TAIL: begin
                    if (i_cls.is_cr) begin
                        n_phase = PH_TAIL_CR;
                    end else if (i_cls.is_lf) begin
                        n_phase = PH_ENDED;
                    end
                end
                PH_TAIL_CR: begin
                    if (i_cls.is_lf) begin
                        n_phase = PH_ENDED;
                    end
                end
                PH_TRAIL, PH_ENDED, PH_FAILED: begin
                    n_phase = w_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_chunk <= '0;
            r_dcnt  <= '0;
            r_lz    <= 1'b0;
            r_ovf   <= 1'b0;
            r_total <= '0;
        end else if (i_go) begin
            r_phase <= n_phase;
            r_chunk <= n_chunk;
            r_dcnt  <= n_dcnt;
            r_lz    <= n_lz;
            r_ovf   <= n_ovf;
            r_total <= n_total;
        end
    end

endmodule
`default_nettype wire

// File: hdl/http_chunked_body_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// path: front register, middle queue, decoder, output queue, result ports
// throughput: one word per cycle unless stalled; each word gives exactly one result word
// the framing state machine updates once per word, the front stage and the
// two-entry queues between the parts absorb stalls on either side
// reset: synchronous, active low; all queues empty, decoder at size-line start
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_unit
// Decodes HTTP/1.1 chunked framing one byte per word.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_unit
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [7:0]   i_in_byte,
    input  wire logic         i_restart,
    output logic              empty,
    input  wire logic         pop,
    output logic              o_data_valid,
    output logic [7:0]        o_data_byte,
    output logic [1:0]        o_status,
    output logic [2:0]        o_error_kind,
    output logic [TOTAL_W-1:0] o_bytes_consumed
);

    logic    w_front_full;
    logic    w_front_valid;
    t_cls    w_front_cls;
    logic    w_mid_full;
    logic    w_mid_empty;
    t_cls    w_mid_cls;
    logic    w_out_full;
    logic    w_out_empty;
    logic    w_go;
    t_result w_res;
    t_result w_head;

    assign full  = w_front_full || !i_rst_n;
    assign empty = w_out_empty || !i_rst_n;
    assign w_go  = !w_mid_empty && !w_out_full;

    hcbd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_in_byte (i_in_byte),
        .i_restart (i_restart),
        .o_full    (w_front_full),
        .o_valid   (w_front_valid),
        .o_cls     (w_front_cls),
        .i_take    (!w_mid_full)
    );

    hcbd_queue #(
        .W ($bits(t_cls))
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_din   (w_front_cls),
        .o_full  (w_mid_full),
        .i_pop   (w_go),
        .o_dout  (w_mid_cls),
        .o_empty (w_mid_empty)
    );

    hcbd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_cls   (w_mid_cls),
        .o_res   (w_res)
    );

    hcbd_queue #(
        .W ($bits(t_result))
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_go),
        .i_din   (w_res),
        .o_full  (w_out_full),
        .i_pop   (pop && i_rst_n),
        .o_dout  (w_head),
        .o_empty (w_out_empty)
    );

    assign o_data_valid     = w_head.data_valid;
    assign o_data_byte      = w_head.data_byte;
    assign o_status         = w_head.status;
    assign o_error_kind     = w_head.error_kind;
    assign o_bytes_consumed = w_head.bytes_consumed;

endmodule
`default_nettype wire

// File: hdl/hcbd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_checker
// Port-level checks on the result side of the chunked body decoder.
// ----------------------------------------------------------------------------
module hcbd_checker
    import hcbd_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               empty,
    input wire logic               pop,
    input wire logic               o_data_valid,
    input wire logic [7:0]         o_data_byte,
    input wire logic [1:0]         o_status,
    input wire logic [2:0]         o_error_kind,
    input wire logic [TOTAL_W-1:0] o_bytes_consumed
);

    // payload words carry the payload status and nothing else does
    a_payload_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_data_valid == (o_status == ST_PAYLOAD)))
        else $error("payload flag and status disagree");

    a_err_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_error_kind != ERR_NONE) |-> (o_status == ST_ERROR))
        else $error("error kind without error status");

    a_byte_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_data_valid |-> (o_data_byte == 8'd0))
        else $error("data byte set on a framing word");

    // a stalled result word holds
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_bytes_consumed) && $stable(o_status))
        else $error("result word changed while stalled");

endmodule

bind http_chunked_body_decoder_unit hcbd_checker u_hcbd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .empty            (empty),
    .pop              (pop),
    .o_data_valid     (o_data_valid),
    .o_data_byte      (o_data_byte),
    .o_status         (o_status),
    .o_error_kind     (o_error_kind),
    .o_bytes_consumed (o_bytes_consumed)
);
`default_nettype wire

// File: dv/tb_http_chunked_body_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder_unit
// Self-checking bench for the chunked body decoder: drives byte words through
// the push/full side, pops result words with random stalls, and compares each
// result word field by field against a cycle-free decoder model kept in a
// small scoreboard. Stimulus is a directed set followed by random bodies,
// corrupted bodies, oversized size lines and raw noise.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder_unit
    import hcbd_pkg::*;
();

    localparam int SZ         = SIZE_BITS_DEF;
    localparam int RANDOM_N   = 550;
    localparam int CYCLE_CAP  = 2000000;
    localparam int DRAIN_WAIT = 8;

    class decoded_word_board;
        t_phase             phase;
        logic [SZ-1:0]      chunk_left;
        logic [DCNT_W-1:0]  digit_count;
        bit                 lead_zero;
        bit                 overflowed;
        logic [TOTAL_W-1:0] byte_total;
        t_result            want_q[$];
        int                 fail_count;
        int                 word_count;

        function new();
            clear_decoder();
            fail_count = 0;
            word_count = 0;
        endfunction

        function void clear_decoder();
            phase       = PH_LEAD;
            chunk_left  = '0;
            digit_count = '0;
            lead_zero   = 1'b0;
            overflowed  = 1'b0;
            byte_total  = '0;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SP || c == CH_HT || c == CH_CR;
        endfunction

        function t_result decode_byte(logic [7:0] c, logic rs);
            t_result    r;
            t_err       err;
            logic [4:0] d;
            bit         line_end;
            r.data_valid     = 1'b0;
            r.data_byte      = 8'h00;
            r.status         = ST_FRAMING;
            r.error_kind     = ERR_NONE;
            err              = ERR_NONE;
            line_end         = 1'b0;
            if (rs) clear_decoder();
            if (phase == PH_ENDED) begin
                r.status = ST_END;
            end else if (phase == PH_FAILED) begin
                r.status = ST_ERROR;
            end else begin
                byte_total = byte_total + 1'b1;
                if (c >= CH_ZERO && c <= CH_NINE) d = 5'(c - CH_ZERO);
                else if (c >= CH_LA && c <= CH_LF_H) d = 5'(c - CH_LA + 8'd10);
                else if (c >= CH_UA && c <= CH_UF) d = 5'(c - CH_UA + 8'd10);
                else d = 5'd16;
                case (phase)
                    PH_LEAD: begin
                        if (!(is_blank(c) || c == CH_LF)) begin
                            if (d[4]) begin
                                err = ERR_NON_HEX;
                            end else begin
                                chunk_left  = SZ'(d[3:0]);
                                digit_count = 1;
                                lead_zero   = (d == 0);
                                overflowed  = 1'b0;
                                phase       = PH_DIGITS;
                            end
                        end
                    end
                    PH_DIGITS: begin
                        if (!d[4]) begin
                            // extra leading zeros are dropped
                            if (!(lead_zero && c == CH_ZERO)) begin
                                lead_zero = 1'b0;
                                if (digit_count >= MAX_DIGITS) begin
                                    err = ERR_TOO_LONG;
                                end else begin
                                    if (chunk_left[SZ-1:SZ-4] != 0) overflowed = 1'b1;
                                    else chunk_left = {chunk_left[SZ-5:0], d[3:0]};
                                    digit_count = digit_count + 1'b1;
                                end
                            end
                        end else if (is_blank(c)) begin
                            phase = PH_TRAIL;
                        end else if (c != CH_LF) begin
                            err = ERR_NO_LF;
                        end else begin
                            line_end = 1'b1;
                        end
                    end
                    PH_TRAIL: begin
                        if (!is_blank(c)) begin
                            if (c != CH_LF) err = ERR_NO_LF;
                            else line_end = 1'b1;
                        end
                    end
                    PH_DATA: begin
                        r.data_valid = 1'b1;
                        r.data_byte  = c;
                        r.status     = ST_PAYLOAD;
                        if (chunk_left != 0) chunk_left = chunk_left - 1'b1;
                        if (chunk_left == 0) phase = PH_LEAD;
                    end
                    PH_TAIL: begin
                        if (c == CH_CR) begin
                            phase = PH_TAIL_CR;
                        end else if (c == CH_LF) begin
                            phase    = PH_ENDED;
                            r.status = ST_END;
                        end else begin
                            err = ERR_TAIL_LF;
                        end
                    end
                    default: begin
                        if (c == CH_LF) begin
                            phase    = PH_ENDED;
                            r.status = ST_END;
                        end else begin
                            err = ERR_TAIL_LF;
                        end
                    end
                endcase
                if (line_end) begin
                    if (overflowed) begin
                        err = ERR_TOO_LARGE;
                    end else begin
                        digit_count = '0;
                        lead_zero   = 1'b0;
                        phase       = (chunk_left != 0) ? PH_DATA : PH_TAIL;
                    end
                end
                if (err != ERR_NONE) begin
                    r.status = ST_ERROR;
                    phase    = PH_FAILED;
                end
            end
            r.error_kind     = err;
            r.bytes_consumed = byte_total;
            return r;
        endfunction

        function void take_byte(logic [7:0] c, logic rs);
            want_q.push_back(decode_byte(c, rs));
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            if (fail_count < 50)
                $display("mismatch at result word %0d, %s: got %0h expected %0h",
                         word_count, what, got, want);
            fail_count++;
        endtask

        task match_result(logic dv, logic [7:0] db, logic [1:0] st, logic [2:0] ek,
                          logic [63:0] bc);
            t_result w;
            if (want_q.size() == 0) begin
                report_mismatch("unexpected word", 64'(st), 64'(0));
            end else begin
                w = want_q.pop_front();
                if (dv !== w.data_valid) report_mismatch("data_valid", 64'(dv), 64'(w.data_valid));
                if (db !== w.data_byte) report_mismatch("data_byte", 64'(db), 64'(w.data_byte));
                if (st !== w.status) report_mismatch("status", 64'(st), 64'(w.status));
                if (ek !== w.error_kind) report_mismatch("error_kind", 64'(ek), 64'(w.error_kind));
                if (bc !== w.bytes_consumed) report_mismatch("bytes_consumed", bc, w.bytes_consumed);
            end
            word_count++;
        endtask

        function int pending();
            return want_q.size();
        endfunction
    endclass

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               push      = 1'b0;
    logic               full;
    logic [7:0]         i_in_byte = 8'h00;
    logic               i_restart = 1'b0;
    logic               empty;
    logic               pop       = 1'b0;
    logic               o_data_valid;
    logic [7:0]         o_data_byte;
    logic [1:0]         o_status;
    logic [2:0]         o_error_kind;
    logic [TOTAL_W-1:0] o_bytes_consumed;

    decoded_word_board sb;
    logic [8:0]        word_q[$];
    bit                next_restart;
    bit                drain_quiet = 1'b0;
    int unsigned       stall_left  = 0;
    int unsigned       pop_gap     = 0;
    int unsigned       cycle_count = 0;

    http_chunked_body_decoder_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_in_byte        (i_in_byte),
        .i_restart        (i_restart),
        .empty            (empty),
        .pop              (pop),
        .o_data_valid     (o_data_valid),
        .o_data_byte      (o_data_byte),
        .o_status         (o_status),
        .o_error_kind     (o_error_kind),
        .o_bytes_consumed (o_bytes_consumed)
    );

    always #1 i_clk = ~i_clk;

    function automatic int unsigned pick_gap(bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // accepted words on both sides, sampled with pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) sb.take_byte(i_in_byte, i_restart);
        if (i_rst_n && pop && !empty)
            sb.match_result(o_data_valid, o_data_byte, o_status, o_error_kind,
                            o_bytes_consumed);
    end

    // result side with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop        <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            pop        <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (pop && !empty) begin
            if ($urandom_range(0, 49) == 0) drain_quiet <= ~drain_quiet;
            pop_gap     = pick_gap(drain_quiet);
            stall_left <= pop_gap;
            pop        <= (pop_gap == 0);
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic add_word(input logic [7:0] b);
        word_q.push_back({next_restart, b});
        next_restart = 1'b0;
    endtask

    // size line: optional whitespace, extra zeros, ndig hex digits of val, LF
    task automatic add_size_line(input logic [79:0] val, input int ndig);
        logic [7:0] lws[4];
        logic [3:0] nib;
        logic [7:0] ch;
        lws = '{CH_SP, CH_HT, CH_CR, CH_LF};
        repeat ($urandom_range(0, 3)) add_word(lws[$urandom_range(0, 3)]);
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) add_word(CH_ZERO);
        for (int i = ndig - 1; i >= 0; i--) begin
            nib = val[i*4 +: 4];
            if (nib < 10) ch = CH_ZERO + 8'(nib);
            else ch = ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(nib) - 8'd10;
            add_word(ch);
        end
        repeat ($urandom_range(0, 2)) add_word(lws[$urandom_range(0, 2)]);
        add_word(CH_LF);
    endtask

    task automatic add_body();
        int unsigned size;
        int          nd;
        int          r;
        repeat ($urandom_range(0, 3)) begin
            r = $urandom_range(0, 99);
            if (r < 80) size = $urandom_range(1, 6);
            else if (r < 96) size = $urandom_range(7, 40);
            else size = $urandom_range(41, 300);
            nd = 1;
            while ((size >> (4 * nd)) != 0) nd++;
            add_size_line(80'(size), nd);
            repeat (size) add_word(8'($urandom_range(0, 255)));
        end
        add_size_line(80'd0, 1);
        if ($urandom_range(0, 1)) add_word(CH_CR);
        add_word(CH_LF);
        // words past the end are not consumed
        repeat ($urandom_range(0, 2)) add_word(8'($urandom_range(0, 255)));
    endtask

    task automatic add_sequence();
        int          kind;
        int          first;
        int          pick;
        logic [79:0] val;
        kind         = $urandom_range(0, 99);
        next_restart = 1'b1;
        if (kind < 55) begin
            add_body();
        end else if (kind < 72) begin
            first = word_q.size();
            add_body();
            pick = $urandom_range(first, word_q.size() - 1);
            word_q[pick][7:0] = 8'($urandom_range(0, 255));
        end else if (kind < 82) begin
            // long size lines: overflow, too many digits, huge chunk cut by restart
            val = {16'($urandom), 32'($urandom), 32'($urandom)};
            add_size_line(val, $urandom_range(14, 20));
            repeat ($urandom_range(1, 4)) add_word(8'($urandom_range(0, 255)));
        end else begin
            next_restart = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 10)) begin
                add_word(8'($urandom_range(0, 255)));
                next_restart = ($urandom_range(0, 7) == 0);
            end
        end
    endtask

    task automatic send_word(input logic [8:0] w, input bit quiet);
        int unsigned gap;
        gap = pick_gap(quiet);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_byte <= w[7:0];
        i_restart <= w[8];
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    initial begin
        int  directed_n;
        bit  feed_quiet;
        sb           = new();
        feed_quiet   = 1'b0;

        // bare last chunk, then a word after the end
        next_restart = 1'b1;
        add_word(CH_ZERO); add_word(CH_LF); add_word(CH_LF); add_word("x");
        // non-hex size start, then a word after the failure
        next_restart = 1'b1;
        add_word(CH_SP); add_word("g"); add_word("a");
        // digit followed by neither whitespace nor LF
        next_restart = 1'b1;
        add_word(CH_UF); add_word("x");
        // one-byte chunk, last chunk whose CR is not followed by LF
        next_restart = 1'b1;
        add_word(CH_CR); add_word("1"); add_word(CH_HT); add_word(CH_CR); add_word(CH_LF);
        add_word(8'hff); add_word(CH_ZERO); add_word(CH_LF); add_word(CH_CR); add_word("z");
        // leading zeros collapse, payload extremes
        next_restart = 1'b1;
        add_word(CH_ZERO); add_word(CH_ZERO); add_word("2"); add_word(CH_LF);
        add_word(8'h00); add_word(8'h80);
        directed_n = word_q.size();

        while (word_q.size() < directed_n + RANDOM_N) add_sequence();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (word_q[i]) begin
            if (i % 64 == 0) feed_quiet = ($urandom_range(0, 3) == 0);
            send_word(word_q[i], feed_quiet);
        end
        push <= 1'b0;
        // let the last accepted word reach the scoreboard first
        @(posedge i_clk);

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/hcbd_pkg.sv
hdl/hcbd_queue.sv
hdl/hcbd_front.sv
hdl/hcbd_back.sv
hdl/http_chunked_body_decoder_unit.sv
hdl/hcbd_checker.sv
dv/tb_http_chunked_body_decoder_unit.sv
